@@ src/gpb_pkg.sv @@
// Shared types and constants of the grid path balance block.
package gpb_pkg;

	// Configuration port geometry.
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 5;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_W-1:0] CFG_ROW_COUNT    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_COLUMN_COUNT = 2'd1;

	// Count value loaded into both count registers at reset.
	localparam logic [CFG_DATA_W-1:0] CFG_COUNT_RESET = 5'd16;

	// Controls for one cell update.
	typedef struct packed {
		logic start;    // top-left cell: begin from balance zero
		logic top_en;   // merge the set of the cell above
		logic left_en;  // merge the set of the cell to the left
		logic up;       // cell is 1: raise the balance, else lower it
	} step_ctrl_t;

endpackage

@@ src/grid_path_balance_reachability.sv @@
// Top level of the grid path balance reachability block.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  cell    | in        | cell_valid/cell_stall | cell_value (1 bit)
//  result  | out       | result_valid/_stall   | path_exists (1 bit)
//  cfg     | in        | cfg_valid/cfg_ready   | cfg_index (2 b), cfg_data (5 b)
//
// One cell request is taken every cycle while the cell channel is not stalled;
// the balance set of a cell is built in the cycle it is accepted and written
// to the column RAM and the left register. The result of a grid's last cell
// sits in the output register from the next cycle. The column RAM is read
// ahead at the next column position. The cell channel stalls only when the
// last cell of a grid arrives while the previous result still waits and is
// stalled. Reset clears positions and loads both counts with 16 (capped at
// the size bounds); the column RAM needs no clearing since the first row never
// reads it. A write to a count register restarts the grid.
module grid_path_balance_reachability #(
	parameter int MAX_ROWS = 16,
	parameter int MAX_COLS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// cell channel
	input  logic                               cell_valid,
	output logic                               cell_stall,
	input  logic                               cell_value,
	// result channel
	output logic                               result_valid,
	input  logic                               result_stall,
	output logic                               path_exists,
	// configuration channel
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [gpb_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [gpb_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int CENTER = MAX_ROWS + MAX_COLS - 1;
	localparam int SET_W  = 2 * CENTER + 1;
	localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	// Index of the last row or column for a count: zero counts as one,
	// counts beyond the bound saturate at it.
	function automatic int last_index(input logic [gpb_pkg::CFG_DATA_W-1:0] v,
	                                  input int bound);
		int cnt;
		cnt = int'(v);
		if (cnt == 0) begin
			cnt = 1;
		end
		if (cnt > bound) begin
			cnt = bound;
		end
		return cnt - 1;
	endfunction

	localparam logic [ROW_W-1:0] ROW_LAST_RST =
		ROW_W'(last_index(gpb_pkg::CFG_COUNT_RESET, MAX_ROWS));
	localparam logic [COL_W-1:0] COL_LAST_RST =
		COL_W'(last_index(gpb_pkg::CFG_COUNT_RESET, MAX_COLS));

	logic [ROW_W-1:0] row_last_q, row_last_d;
	logic [COL_W-1:0] col_last_q, col_last_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic [COL_W-1:0] col_q, col_d;
	logic [SET_W-1:0] left_q, left_d;
	logic             result_valid_q, result_valid_d;
	logic             path_q;

	// Write forwarding around the RAM's registered read.
	logic             byp_valid_q;
	logic [COL_W-1:0] byp_addr_q;
	logic [SET_W-1:0] byp_data_q;

	logic             cfg_fire;
	logic             cell_fire;
	logic             at_last_col;
	logic             at_last_row;
	logic             at_last;
	logic             ram_we;
	logic [SET_W-1:0] ram_rdata;
	logic [SET_W-1:0] top_set;
	logic [SET_W-1:0] next_set;
	gpb_pkg::step_ctrl_t ctrl;

	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid & cfg_ready;

	assign at_last_col = (col_q == col_last_q);
	assign at_last_row = (row_q == row_last_q);
	assign at_last     = at_last_col & at_last_row;

	// Only a grid's last cell needs room in the output register.
	assign cell_stall = at_last & result_valid_q & result_stall;
	assign cell_fire  = cell_valid & ~cell_stall;

	assign ctrl.start   = (row_q == '0) & (col_q == '0);
	assign ctrl.top_en  = (row_q != '0);
	assign ctrl.left_en = (col_q != '0);
	assign ctrl.up      = cell_value;

	// The column just written in the last cycle is not yet in the read data.
	assign top_set = (byp_valid_q && (byp_addr_q == col_q)) ? byp_data_q : ram_rdata;

	gpb_step #(
		.SET_W  (SET_W),
		.CENTER (CENTER)
	) u_step (
		.ctrl     (ctrl),
		.top_set  (top_set),
		.left_set (left_q),
		.next_set (next_set)
	);

	assign ram_we = cell_fire & ~cfg_fire;

	gpb_ram #(
		.WIDTH (SET_W),
		.DEPTH (MAX_COLS)
	) u_col_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (col_q),
		.wdata (next_set),
		.raddr (col_d),
		.rdata (ram_rdata)
	);

	// Count registers: a write to a known index loads its last index.
	always_comb begin
		row_last_d = row_last_q;
		col_last_d = col_last_q;
		if (cfg_fire) begin
			unique case (cfg_index)
				gpb_pkg::CFG_ROW_COUNT: begin
					row_last_d = ROW_W'(last_index(cfg_data, MAX_ROWS));
				end
				gpb_pkg::CFG_COLUMN_COUNT: begin
					col_last_d = COL_W'(last_index(cfg_data, MAX_COLS));
				end
				default: begin
				end
			endcase
		end
	end

	// Advance the grid position and the left set; restart on a count write.
	always_comb begin
		row_d  = row_q;
		col_d  = col_q;
		left_d = left_q;
		priority if (cfg_fire && (cfg_index == gpb_pkg::CFG_ROW_COUNT ||
		                          cfg_index == gpb_pkg::CFG_COLUMN_COUNT)) begin
			row_d  = '0;
			col_d  = '0;
			left_d = '0;
		end else if (ram_we) begin
			if (at_last_col) begin
				col_d  = '0;
				left_d = '0;
				row_d  = at_last_row ? '0 : row_q + ROW_W'(1);
			end else begin
				col_d  = col_q + COL_W'(1);
				left_d = next_set;
			end
		end else begin
		end
	end

	// Hold a result until taken; load a new one at a grid's last cell.
	assign result_valid_d = (ram_we & at_last) | (result_valid_q & result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_last_q     <= ROW_LAST_RST;
			col_last_q     <= COL_LAST_RST;
			row_q          <= '0;
			col_q          <= '0;
			left_q         <= '0;
			result_valid_q <= 1'b0;
			byp_valid_q    <= 1'b0;
		end else begin
			row_last_q     <= row_last_d;
			col_last_q     <= col_last_d;
			row_q          <= row_d;
			col_q          <= col_d;
			left_q         <= left_d;
			result_valid_q <= result_valid_d;
			byp_valid_q    <= ram_we;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			byp_addr_q <= col_q;
			byp_data_q <= next_set;
		end
		if (ram_we && at_last) begin
			path_q <= next_set[CENTER];
		end
	end

	assign result_valid = result_valid_q;
	assign path_exists  = path_q;

endmodule

@@ src/gpb_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gpb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/gpb_step.sv @@
// One cell update: merge neighbor balance sets and shift by the cell value.
module gpb_step #(
	parameter int SET_W  = 63,
	parameter int CENTER = 31
) (
	input  gpb_pkg::step_ctrl_t ctrl,
	input  logic [SET_W-1:0]    top_set,
	input  logic [SET_W-1:0]    left_set,
	output logic [SET_W-1:0]    next_set
);

	logic [SET_W-1:0] merged;

	always_comb begin
		merged = '0;
		if (ctrl.start) begin
			merged[CENTER] = 1'b1;
		end else begin
			if (ctrl.top_en) begin
				merged = merged | top_set;
			end
			if (ctrl.left_en) begin
				merged = merged | left_set;
			end
		end
	end

	// Shift with zero fill; bits leaving the set are dropped.
	assign next_set = ctrl.up ? {merged[SET_W-2:0], 1'b0} : {1'b0, merged[SET_W-1:1]};

endmodule

@@ src/gpb_checker.sv @@
// Port-level checks of the grid path balance block, bound to the top level.
module gpb_checker (
	input logic clk,
	input logic arst_n,
	input logic cell_valid,
	input logic cell_stall,
	input logic result_valid,
	input logic result_stall,
	input logic path_exists,
	input logic cfg_valid,
	input logic cfg_ready
);

	// A stalled result stays offered.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result request dropped while stalled");

	// A stalled result keeps its value.
	a_result_stable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(path_exists))
		else $error("result payload changed while stalled");

	// A new result only follows an accepted cell.
	a_result_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cell_valid && !cell_stall))
		else $error("result appeared without an accepted cell");

	// Cells are held back only by a waiting, stalled result.
	a_cell_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		cell_stall |-> result_valid && result_stall)
		else $error("cell channel stalled with no result waiting");

	// Configuration writes are always taken.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind grid_path_balance_reachability gpb_checker u_gpb_checker (.*);

@@ dv/grid_path_balance_reachability_tb.sv @@
// Self-checking testbench for the grid path balance reachability block.
module testbench;

	localparam int MAX_ROWS = 16;
	localparam int MAX_COLS = 16;
	// Balance b lives at bit b + CENTER; wide enough for the largest grid.
	localparam int CENTER = MAX_ROWS + MAX_COLS - 1;
	localparam int SET_W  = 2 * CENTER + 1;

	typedef logic [gpb_pkg::CFG_INDEX_W-1:0] index_t;
	typedef logic [gpb_pkg::CFG_DATA_W-1:0]  count_t;

	// Index that names no register; a write there must leave the grid alone.
	localparam index_t CFG_UNUSED_INDEX = 2'd3;

	localparam int TOTAL_CELLS   = 1450;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 6;

	typedef enum int {FILL_ONES, FILL_ZEROS, FILL_ALTERNATING, FILL_RANDOM} fill_t;

	// Tracks reachable balances per column and queues the grid verdicts.
	class balance_tracker;
		logic [SET_W-1:0]      column_bits [MAX_COLS];
		logic [SET_W-1:0]      left_bits;
		int unsigned           row_at;
		int unsigned           col_at;
		count_t                rows_reg;
		count_t                cols_reg;
		logic                  path_exists_due [$];
		int unsigned           mismatches;
		int unsigned           results_checked;

		function new();
			rows_reg = gpb_pkg::CFG_COUNT_RESET;
			cols_reg = gpb_pkg::CFG_COUNT_RESET;
			mismatches = 0;
			results_checked = 0;
			foreach (column_bits[i]) column_bits[i] = '0;
			restart();
		endfunction

		function void restart();
			left_bits = '0;
			row_at = 0;
			col_at = 0;
		endfunction

		// Zero counts mean one; oversize counts saturate at the bound.
		function int unsigned in_use(count_t v, int unsigned bound);
			if (v == 0)
				return 1;
			if (v > bound)
				return bound;
			return 32'(v);
		endfunction

		function int unsigned grid_cells();
			return in_use(rows_reg, MAX_ROWS) * in_use(cols_reg, MAX_COLS);
		endfunction

		function void write_reg(index_t idx, count_t data);
			if (idx == gpb_pkg::CFG_ROW_COUNT)
				rows_reg = data;
			else if (idx == gpb_pkg::CFG_COLUMN_COUNT)
				cols_reg = data;
			else
				return;
			restart();
		endfunction

		function void take_cell(logic up);
			int unsigned      rows;
			int unsigned      cols;
			int unsigned      r;
			int unsigned      c;
			logic [SET_W-1:0] merged;
			logic [SET_W-1:0] moved;
			rows = in_use(rows_reg, MAX_ROWS);
			cols = in_use(cols_reg, MAX_COLS);
			r = (row_at >= rows) ? rows - 1 : row_at;
			c = (col_at >= cols) ? cols - 1 : col_at;
			merged = '0;
			if (r == 0 && c == 0) begin
				merged[CENTER] = 1'b1;
			end else begin
				if (r > 0)
					merged |= column_bits[c];
				if (c > 0)
					merged |= left_bits;
			end
			moved = up ? (merged << 1) : (merged >> 1);
			column_bits[c] = moved;
			left_bits = moved;
			if (c + 1 < cols) begin
				col_at = c + 1;
				row_at = r;
				return;
			end
			left_bits = '0;
			col_at = 0;
			if (r + 1 < rows) begin
				row_at = r + 1;
				return;
			end
			row_at = 0;
			path_exists_due.push_back(moved[CENTER]);
		endfunction

		task flag_mismatch(string what);
			$display("MISMATCH at %0t: %s", $realtime, what);
			mismatches++;
		endtask

		task match_result(logic got);
			logic want;
			if (path_exists_due.size() == 0) begin
				flag_mismatch($sformatf("path_exists=%b with no grid outstanding", got));
				return;
			end
			want = path_exists_due.pop_front();
			results_checked++;
			if (got !== want)
				flag_mismatch($sformatf("path_exists=%b, expected %b", got, want));
		endtask

		function int unsigned outstanding();
			return path_exists_due.size();
		endfunction
	endclass

	logic   clk;
	logic   arst_n       = 1'b0;
	logic   cell_valid   = 1'b0;
	logic   cell_stall;
	logic   cell_value   = 1'b0;
	logic   result_valid;
	logic   result_stall = 1'b0;
	logic   path_exists;
	logic   cfg_valid    = 1'b0;
	logic   cfg_ready;
	index_t cfg_index    = '0;
	count_t cfg_data     = '0;

	balance_tracker tracker;
	int unsigned    cells_sent       = 0;
	int unsigned    writes_done      = 0;
	int unsigned    cell_idle_mode   = 0;
	int unsigned    result_idle_mode = 0;
	bit             hold_request     = 1'b0;

	grid_path_balance_reachability #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cell_valid  (cell_valid),
		.cell_stall  (cell_stall),
		.cell_value  (cell_value),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.path_exists (path_exists),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#7000000;
		$display("TIMEOUT: requests still outstanding");
		$display("grid_path_balance_reachability verification failed");
		$finish;
	end

	// Length of an idle run: mode 0 never idles, 1 idles lightly, 2 heavily.
	// Most runs are short; a few are long so gaps land on every phase.
	function automatic int unsigned idle_len(int unsigned mode);
		int unsigned roll;
		if (mode == 0)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < ((mode == 1) ? 80 : 50))
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Mostly small grids; now and then a zero, the bound, or a count past it.
	function automatic count_t pick_count();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 6)
			return '0;
		if (roll < 12)
			return count_t'(MAX_ROWS);
		if (roll < 16)
			return count_t'($urandom_range(17, 31));
		return count_t'($urandom_range(1, 6));
	endfunction

	// Result side: check every accepted result, then pick the next stall.
	// A hold request from the stimulus turns into one long stall run, counted
	// here, while the sender keeps offering cells.
	initial begin
		int unsigned hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && result_valid && !result_stall)
				tracker.match_result(path_exists);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left == 0)
				hold_left = idle_len(result_idle_mode);
			if (hold_left != 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Offer one cell request and hold it until taken; then record it and
	// optionally drop valid for a gap. With no gap, valid stays high.
	task automatic offer_cell(logic v);
		int unsigned gap;
		cell_valid <= 1'b1;
		cell_value <= v;
		do @(posedge clk); while (cell_stall);
		tracker.take_cell(v);
		cells_sent++;
		gap = idle_len(cell_idle_mode);
		if (gap != 0) begin
			cell_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stream cells of one grid (or the head of one) with a chosen fill.
	task automatic offer_grid(int unsigned cells);
		fill_t       fill;
		int unsigned k;
		int unsigned roll;
		roll = $urandom_range(0, 9);
		fill = (roll == 0) ? FILL_ONES : (roll == 1) ? FILL_ZEROS :
			(roll == 2) ? FILL_ALTERNATING : FILL_RANDOM;
		for (k = 0; k < cells; k++) begin
			case (fill)
				FILL_ONES:        offer_cell(1'b1);
				FILL_ZEROS:       offer_cell(1'b0);
				FILL_ALTERNATING: offer_cell(k % 2 == 0);
				default:          offer_cell(1'($urandom_range(0, 1)));
			endcase
		end
	endtask

	// Register write; valid drops before anything else happens.
	task automatic write_reg(index_t idx, count_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		tracker.write_reg(idx, data);
		writes_done++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Stop offering cells, wait for every due verdict, then let the
	// pipeline drain before touching registers.
	task automatic settle();
		cell_valid <= 1'b0;
		while (tracker.outstanding() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned k;
		count_t      rows;
		count_t      cols;
		tracker = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: unused index, zero counts (1x1 grids, both cell values).
		write_reg(CFG_UNUSED_INDEX, 5'd21);
		write_reg(gpb_pkg::CFG_ROW_COUNT, 5'd0);
		write_reg(gpb_pkg::CFG_COLUMN_COUNT, 5'd0);
		offer_cell(1'b0);
		offer_cell(1'b1);
		settle();

		// Row count past the bound saturates: a 16x1 column, balanced content.
		write_reg(gpb_pkg::CFG_ROW_COUNT, 5'd31);
		write_reg(gpb_pkg::CFG_COLUMN_COUNT, 5'd1);
		for (k = 0; k < MAX_ROWS; k++)
			offer_cell(k % 2 == 0);
		settle();

		// Abandon a 2x3 grid halfway; the next write restarts it as 2x2.
		write_reg(gpb_pkg::CFG_ROW_COUNT, 5'd2);
		write_reg(gpb_pkg::CFG_COLUMN_COUNT, 5'd3);
		offer_cell(1'b1);
		offer_cell(1'b0);
		offer_cell(1'b1);
		settle();
		write_reg(gpb_pkg::CFG_COLUMN_COUNT, 5'd2);
		offer_cell(1'b1);
		offer_cell(1'b1);
		offer_cell(1'b0);
		offer_cell(1'b0);
		settle();

		// Back-pressure: 1x1 grids make every cell a result, so a long
		// result hold fills the output and stalls the cell channel.
		write_reg(gpb_pkg::CFG_ROW_COUNT, 5'd1);
		write_reg(gpb_pkg::CFG_COLUMN_COUNT, 5'd1);
		cell_idle_mode = 0;
		hold_request = 1'b1;
		repeat (40) offer_cell(1'($urandom_range(0, 1)));
		settle();

		// Random phases: fresh sizes, fresh idle behavior, a few whole grids,
		// sometimes a broken grid that the next write throws away.
		while (cells_sent < TOTAL_CELLS) begin
			rows = pick_count();
			cols = pick_count();
			write_reg(gpb_pkg::CFG_ROW_COUNT, rows);
			write_reg(gpb_pkg::CFG_COLUMN_COUNT, cols);
			cell_idle_mode = $urandom_range(0, 2);
			result_idle_mode = $urandom_range(0, 2);
			repeat ($urandom_range(1, 4))
				if (cells_sent < TOTAL_CELLS)
					offer_grid(tracker.grid_cells());
			if ($urandom_range(0, 4) == 0 && tracker.grid_cells() > 1)
				offer_grid($urandom_range(1, tracker.grid_cells() - 1));
			settle();
		end

		settle();
		$display("run covered %0d cells and %0d grid verdicts over %0d register writes",
			cells_sent, tracker.results_checked, writes_done);
		$display("incl. count extremes, abandoned grids and a %0d-cycle result hold",
			HOLD_CYCLES);
		if (tracker.mismatches == 0) begin
			$display("grid_path_balance_reachability verification clean");
		end else begin
			$display("grid_path_balance_reachability verification failed");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/gpb_pkg.sv
src/gpb_ram.sv
src/gpb_step.sv
src/grid_path_balance_reachability.sv
src/gpb_checker.sv
dv/grid_path_balance_reachability_tb.sv
